// ===== src/uord_pkg.sv =====
// ----------------------------------------------------------------------------
// uord_pkg: shared types and constants for USB OTG role detection
// Mode, role and event codes, the per-tick state record, timer sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package uord_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int IDX_W      = 2;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
	localparam logic [CFG_W-1:0]      DEB_RESET = CFG_W'(100);
	localparam logic [CFG_W-1:0]      STARTUP_DEB_RESET = CFG_W'(1500);

	typedef enum logic [2:0] {
		ST_UNKNOWN    = 3'd0,
		ST_DEVICE     = 3'd1,
		ST_HOST       = 3'd2,
		ST_DEB_DEVICE = 3'd3,
		ST_DEB_HOST   = 3'd4,
		ST_FAULT      = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ROLE_NONE   = 2'd0,
		ROLE_DEVICE = 2'd1,
		ROLE_HOST   = 2'd2
	} role_t;

	typedef enum logic [1:0] {
		EV_OC_LOW = 2'd0,
		EV_ID_HI  = 2'd1,
		EV_ID_LOW = 2'd2,
		EV_EXPIRE = 2'd3
	} event_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE         = 2'd0,
		REG_STARTUP_DEBOUNCE = 2'd1,
		REG_OTG_ENABLED      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		mode_t                 mode;
		logic [TIMER_BITS-1:0] cd;
		logic                  act;
		role_t                 role;
		logic                  sw;
	} step_t;

	// clamp a programmed duration to the timer range
	function automatic logic [TIMER_BITS-1:0] sat_dur(logic [CFG_W-1:0] d);
		logic [63:0] wide;
		wide = 64'(d);
		if (wide > 64'(TIMER_MAX))
			return TIMER_MAX;
		return TIMER_BITS'(wide);
	endfunction

endpackage

`default_nettype wire

// ===== src/usb_otg_role_detect.sv =====
// ----------------------------------------------------------------------------
// usb_otg_role_detect: OTG ID pin role detection with debounce
// Per millisecond tick: overcurrent, ID pin and timer expiry update the mode.
// ----------------------------------------------------------------------------
// One request in, one result out per tick. A tick is taken every clock cycle
// unless in_stall is high; it is held in the input register, the mode/timer/role
// update is combinational and lands in the result register, so throughput is
// one tick per cycle while the result register is not stalled.
// The input register holds a tick while the result register is stalled, so
// one more tick is taken while a result waits. Registers may be written only
// while no tick is in flight.
`default_nettype none

module usb_otg_role_detect
	import uord_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             id_level,
	input  wire logic             oc_level,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [2:0]            fsm_state,
	output logic [1:0]            role,
	output logic                  role_switch,
	output logic                  fault
);

	logic [CFG_W-1:0] deb_q;
	logic [CFG_W-1:0] sdeb_q;
	logic             otg_q;

	logic valid_s1;
	logic id_s1;
	logic oc_s1;
	logic adv_s1;

	mode_t                 mode_q;
	logic [TIMER_BITS-1:0] cd_q;
	logic                  act_q;
	role_t                 role_q;

	logic  out_valid_q;
	step_t nxt;

	function automatic step_t enter(step_t s, mode_t m, logic otg);
		step_t r;
		role_t nr;
		r = s;
		if (m == s.mode)
			return r;
		r.mode = m;
		if (m == ST_DEVICE)
			nr = ROLE_DEVICE;
		else if (m == ST_HOST)
			nr = ROLE_HOST;
		else
			return r;
		if (nr != r.role) begin
			r.role = nr;
			if (otg)
				r.sw = 1'b1;
		end
		return r;
	endfunction

	function automatic step_t load(step_t s, logic [CFG_W-1:0] d);
		step_t r;
		r = s;
		r.cd = sat_dur(d);
		r.act = 1'b1;
		return r;
	endfunction

	function automatic step_t handle(step_t s, event_t ev, logic [CFG_W-1:0] deb,
			logic [CFG_W-1:0] sdeb, logic otg);
		step_t r;
		r = s;
		unique case (s.mode)
			ST_UNKNOWN: begin
				if (ev == EV_ID_LOW) begin
					r = load(enter(r, ST_DEB_HOST, otg), sdeb);
				end else if (ev == EV_ID_HI) begin
					r = load(enter(r, ST_DEB_DEVICE, otg), sdeb);
				end else if (ev == EV_OC_LOW) begin
					r = enter(load(r, deb), ST_FAULT, otg);
				end
			end
			ST_DEVICE: begin
				if (ev == EV_ID_LOW)
					r = load(enter(r, ST_DEB_HOST, otg), deb);
				else if (ev == EV_OC_LOW)
					r = enter(load(r, deb), ST_FAULT, otg);
			end
			ST_HOST: begin
				if (ev == EV_ID_HI)
					r = load(enter(r, ST_DEB_DEVICE, otg), deb);
				else if (ev == EV_OC_LOW)
					r = enter(load(r, deb), ST_FAULT, otg);
			end
			ST_DEB_DEVICE: begin
				if (ev == EV_ID_LOW) begin
					r = enter(r, ST_HOST, otg);
					r.cd = '0;
					r.act = 1'b0;
				end else if (ev == EV_EXPIRE) begin
					r = enter(r, ST_DEVICE, otg);
				end else if (ev == EV_OC_LOW) begin
					r = enter(load(r, deb), ST_FAULT, otg);
				end
			end
			ST_DEB_HOST: begin
				if (ev == EV_ID_HI) begin
					r = enter(r, ST_DEVICE, otg);
					r.cd = '0;
					r.act = 1'b0;
				end else if (ev == EV_EXPIRE) begin
					r = enter(r, ST_HOST, otg);
				end else if (ev == EV_OC_LOW) begin
					r = enter(load(r, deb), ST_FAULT, otg);
				end
			end
			ST_FAULT: begin
				if (ev == EV_OC_LOW)
					r = load(r, deb);
				else if (ev == EV_EXPIRE)
					r = enter(r, ST_HOST, otg);
			end
			default: begin
				r.mode = ST_UNKNOWN;
			end
		endcase
		return r;
	endfunction

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q  <= DEB_RESET;
			sdeb_q <= STARTUP_DEB_RESET;
			otg_q  <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEBOUNCE:         deb_q  <= wr_data;
				REG_STARTUP_DEBOUNCE: sdeb_q <= wr_data;
				REG_OTG_ENABLED:      otg_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			id_s1 <= id_level;
			oc_s1 <= oc_level;
		end
	end

	// one tick: timer decrement, overcurrent, ID pin, then expiry
	always_comb begin
		step_t s;
		s.mode = mode_q;
		s.cd   = cd_q;
		s.act  = act_q;
		s.role = role_q;
		s.sw   = 1'b0;
		if (s.act && (s.cd != '0))
			s.cd = s.cd - TIMER_BITS'(1);
		if (!oc_s1)
			s = handle(s, EV_OC_LOW, deb_q, sdeb_q, otg_q);
		s = handle(s, id_s1 ? EV_ID_HI : EV_ID_LOW, deb_q, sdeb_q, otg_q);
		if (s.act && (s.cd == '0)) begin
			s.act = 1'b0;
			s = handle(s, EV_EXPIRE, deb_q, sdeb_q, otg_q);
		end
		nxt = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_UNKNOWN;
			cd_q   <= '0;
			act_q  <= 1'b0;
			role_q <= ROLE_NONE;
		end else if (adv_s1) begin
			mode_q <= nxt.mode;
			cd_q   <= nxt.cd;
			act_q  <= nxt.act;
			role_q <= nxt.role;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fsm_state   <= nxt.mode;
			role        <= nxt.role;
			role_switch <= nxt.sw;
			fault       <= (nxt.mode == ST_FAULT);
		end
	end

	assign out_valid = out_valid_q;

	a_idle_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |-> (cd_q == '0))
		else $error("idle timer holds a nonzero count");

	a_device_role: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_DEVICE) |-> (role_q == ROLE_DEVICE))
		else $error("device mode without device role");

	a_host_role: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_HOST) |-> (role_q == ROLE_HOST))
		else $error("host mode without host role");

	a_switch_has_role: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && role_switch) |-> (role != ROLE_NONE) && otg_q)
		else $error("role switch flagged without a role");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1 && out_valid_q)
		else $error("tick dropped while result stalled");

endmodule

`default_nettype wire

// ===== verif/usb_otg_role_detect_test.sv =====
// ----------------------------------------------------------------------------
// usb_otg_role_detect_test: self-checking bench for OTG role detection
// Drives ID/overcurrent ticks under random valid gaps and result stalls,
// predicts mode, role, switch and fault per tick, and checks every result.
// ----------------------------------------------------------------------------

module usb_otg_role_detect_test
	import uord_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;

	typedef struct {
		mode_t mode;
		role_t port_role;
		bit    switched;
		bit    fault;
	} tick_status_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             wr_en       = 1'b0;
	logic [IDX_W-1:0] wr_index    = '0;
	logic [CFG_W-1:0] wr_data     = '0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic             id_level    = 1'b0;
	logic             oc_level    = 1'b1;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic [2:0]       fsm_state;
	logic [1:0]       role;
	logic             role_switch;
	logic             fault;

	usb_otg_role_detect dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.id_level(id_level),
		.oc_level(oc_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fsm_state(fsm_state),
		.role(role),
		.role_switch(role_switch),
		.fault(fault)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// programmed settings as the predictor sees them
	logic [CFG_W-1:0] cfg_debounce = DEB_RESET;
	logic [CFG_W-1:0] cfg_startup  = STARTUP_DEB_RESET;
	bit               cfg_otg      = 1'b1;

	// predicted role-detect state
	mode_t                 pred_mode     = ST_UNKNOWN;
	logic [TIMER_BITS-1:0] pred_count    = '0;
	bit                    pred_armed    = 1'b0;
	role_t                 pred_role     = ROLE_NONE;
	bit                    pred_switched = 1'b0;

	tick_status_t expected_status[$];

	bit idle_on = 1'b1;
	int mismatches = 0;
	int n_ticks = 0;
	int n_results = 0;
	int n_writes = 0;
	int n_switches = 0;
	int n_fault_ticks = 0;

	function automatic void arm_timer(logic [CFG_W-1:0] dur);
		if (64'(dur) > 64'(TIMER_MAX))
			pred_count = TIMER_MAX;
		else
			pred_count = TIMER_BITS'(dur);
		pred_armed = 1'b1;
	endfunction

	function automatic void disarm_timer();
		pred_count = '0;
		pred_armed = 1'b0;
	endfunction

	// re-entering the same role is not a switch
	function automatic void move_to(mode_t next);
		role_t r;
		if (next == pred_mode)
			return;
		pred_mode = next;
		if (next == ST_DEVICE)
			r = ROLE_DEVICE;
		else if (next == ST_HOST)
			r = ROLE_HOST;
		else
			return;
		if (r != pred_role) begin
			pred_role = r;
			if (cfg_otg)
				pred_switched = 1'b1;
		end
	endfunction

	function automatic void apply_event(event_t ev);
		case (pred_mode)
			ST_UNKNOWN: begin
				if (ev == EV_ID_LOW) begin
					move_to(ST_DEB_HOST);
					arm_timer(cfg_startup);
				end else if (ev == EV_ID_HI) begin
					move_to(ST_DEB_DEVICE);
					arm_timer(cfg_startup);
				end else if (ev == EV_OC_LOW) begin
					arm_timer(cfg_debounce);
					move_to(ST_FAULT);
				end
			end
			ST_DEVICE: begin
				if (ev == EV_ID_LOW) begin
					move_to(ST_DEB_HOST);
					arm_timer(cfg_debounce);
				end else if (ev == EV_OC_LOW) begin
					arm_timer(cfg_debounce);
					move_to(ST_FAULT);
				end
			end
			ST_HOST: begin
				if (ev == EV_ID_HI) begin
					move_to(ST_DEB_DEVICE);
					arm_timer(cfg_debounce);
				end else if (ev == EV_OC_LOW) begin
					arm_timer(cfg_debounce);
					move_to(ST_FAULT);
				end
			end
			ST_DEB_DEVICE: begin
				if (ev == EV_ID_LOW) begin
					move_to(ST_HOST);
					disarm_timer();
				end else if (ev == EV_EXPIRE) begin
					move_to(ST_DEVICE);
				end else if (ev == EV_OC_LOW) begin
					arm_timer(cfg_debounce);
					move_to(ST_FAULT);
				end
			end
			ST_DEB_HOST: begin
				if (ev == EV_ID_HI) begin
					move_to(ST_DEVICE);
					disarm_timer();
				end else if (ev == EV_EXPIRE) begin
					move_to(ST_HOST);
				end else if (ev == EV_OC_LOW) begin
					arm_timer(cfg_debounce);
					move_to(ST_FAULT);
				end
			end
			ST_FAULT: begin
				if (ev == EV_OC_LOW)
					arm_timer(cfg_debounce);
				else if (ev == EV_EXPIRE)
					move_to(ST_HOST);
			end
			default: begin
				pred_mode = ST_UNKNOWN;
			end
		endcase
	endfunction

	// order within a tick: overcurrent, then ID pin, then timer expiry
	function automatic tick_status_t predict_tick(bit id, bit oc);
		tick_status_t res;
		pred_switched = 1'b0;
		if (pred_armed && pred_count != 0)
			pred_count--;
		if (!oc)
			apply_event(EV_OC_LOW);
		apply_event(id ? EV_ID_HI : EV_ID_LOW);
		if (pred_armed && pred_count == 0) begin
			disarm_timer();
			apply_event(EV_EXPIRE);
		end
		res.mode = pred_mode;
		res.port_role = pred_role;
		res.switched = pred_switched;
		res.fault = (pred_mode == ST_FAULT);
		return res;
	endfunction

	// called and returns at a falling edge
	task automatic send_tick(bit id, bit oc);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		id_level <= id;
		oc_level <= oc;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_status.push_back(predict_tick(id, oc));
		n_ticks++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		wait_drained();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_DEBOUNCE:         cfg_debounce = val;
			REG_STARTUP_DEBOUNCE: cfg_startup = val;
			REG_OTG_ENABLED:      cfg_otg = val[0];
			default:              ;
		endcase
		n_writes++;
	endtask

	task automatic set_config(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] startup, bit otg);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_STARTUP_DEBOUNCE, startup);
		write_reg(REG_OTG_ENABLED, CFG_W'(otg));
	endtask

	// mostly steady ID runs around the hold time, some overcurrent bursts and noise
	task automatic drive_random(int count);
		int left;
		int span;
		int run_len;
		int kind;
		bit id;
		left = count;
		while (left > 0) begin
			span = (cfg_debounce < 12) ? int'(cfg_debounce) + 3 : 12;
			run_len = $urandom_range(1, span);
			if (run_len > left)
				run_len = left;
			kind = $urandom_range(0, 9);
			id = 1'($urandom_range(0, 1));
			repeat (run_len) begin
				if (kind == 0)
					send_tick(1'($urandom_range(0, 1)), 1'b0);
				else if (kind == 1)
					send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
				else
					send_tick(id, 1'b1);
			end
			left -= run_len;
		end
	endtask

	task automatic test_power_up();
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
	endtask

	// one-tick hold, then a zero hold that expires in the tick that loads it
	task automatic test_short_and_zero_hold();
		set_config(CFG_W'(1), CFG_W'(1), 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		write_reg(REG_OTG_ENABLED, CFG_W'(1));
		write_reg(REG_DEBOUNCE, CFG_W'(0));
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic test_long_hold();
		set_config('1, '1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
	endtask

	task automatic test_random_fast_hold();
		set_config(CFG_W'(1), CFG_W'(1), 1'b1);
		drive_random(350);
	endtask

	task automatic test_random_zero_hold();
		set_config(CFG_W'(0), '1, 1'b0);
		drive_random(300);
	endtask

	task automatic test_random_max_hold();
		set_config('1, CFG_W'(0), 1'b1);
		drive_random(60);
	endtask

	task automatic test_random_settings();
		repeat (4) begin
			set_config(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
			drive_random(200);
		end
	endtask

	task automatic test_quiet_link();
		set_config(CFG_W'(3), CFG_W'(7), 1'b1);
		idle_on = 1'b0;
		drive_random(340);
	endtask

	// result side stall bursts with quiet stretches between them
	initial begin : stall_gen
		int n;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(1, 30);
				repeat (n) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		tick_status_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_results++;
			if (expected_status.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with no request pending: state %0d role %0d",
						$realtime, fsm_state, role);
				mismatches++;
			end else begin
				want = expected_status.pop_front();
				if (fsm_state !== want.mode || role !== want.port_role ||
						role_switch !== want.switched || fault !== want.fault) begin
					if (mismatches < 10)
						$display({"%0t: mismatch exp/got state %0d/%0d role %0d/%0d ",
							"switch %0b/%0b fault %0b/%0b"}, $realtime,
							want.mode, fsm_state, want.port_role, role,
							want.switched, role_switch, want.fault, fault);
					mismatches++;
				end
				n_switches += int'(want.switched);
				n_fault_ticks += int'(want.fault);
			end
		end
	end

	initial begin : watchdog
		int still;
		still = 0;
		while (still < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				still = 0;
			else
				still++;
		end
		$display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
		$display("** usb_otg_role_detect: FAILED **");
		$finish;
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_power_up();
		test_short_and_zero_hold();
		test_long_hold();
		test_random_fast_hold();
		test_random_zero_hold();
		test_random_max_hold();
		test_random_settings();
		test_quiet_link();
		wait_drained();
		repeat (8) @(negedge clk);
		if (expected_status.size() != 0) begin
			$display("%0d results never arrived", expected_status.size());
			mismatches += expected_status.size();
		end
		$display("Covered %0d ticks and %0d results over %0d register writes,",
			n_ticks, n_results, n_writes);
		$display("with %0d role switch ticks and %0d fault ticks; %0d mismatches.",
			n_switches, n_fault_ticks, mismatches);
		if (mismatches == 0)
			$display("** usb_otg_role_detect: PASSED **");
		else
			$display("** usb_otg_role_detect: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
src/uord_pkg.sv
src/usb_otg_role_detect.sv
verif/usb_otg_role_detect_test.sv
